### hw/rtl/pid_with_antiwindup_deadzone_macros.svh
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Concurrent checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PID_WITH_ANTIWINDUP_DEADZONE_MACROS_SVH
`define PID_WITH_ANTIWINDUP_DEADZONE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent
`define PIDAWDZ_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PIDAWDZ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define PIDAWDZ_ASSERT_SAME(lbl, ante, cons, msg)
`define PIDAWDZ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### hw/rtl/pidawdz_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller package
// Widths, register codes, reset values, limits and saturation helpers.
// ----------------------------------------------------------------------------
package pidawdz_pkg;

	// Port and field widths
	localparam int unsigned CFG_IDX_W = 4;
	localparam int unsigned CFG_W     = 32;
	localparam int unsigned LUX_W     = 16;
	localparam int unsigned DB_W      = 16;
	localparam int unsigned DRIVE_W   = 8;

	// Fixed-point layout
	localparam int unsigned LUX_FRAC  = 4;
	localparam int unsigned FRAC_W    = 16;
	localparam int unsigned ERR_W     = LUX_W + 1;
	localparam int unsigned KP_PROD_W = CFG_W + LUX_W + 1;
	localparam int unsigned KI_PROD_W = CFG_W + ERR_W + 1;
	localparam int unsigned KD_PROD_W = CFG_W + ERR_W;
	localparam int unsigned P_W       = 48;
	localparam int unsigned INC_W     = 46;
	localparam int unsigned ACC_W     = 48;
	localparam int unsigned WND_W     = 32;
	localparam int unsigned SUM_W     = 2 * CFG_W + 2;
	localparam int unsigned TOT_W     = ACC_W + 3;
	localparam int unsigned U_W       = TOT_W - FRAC_W;

	// Actuator limits and windup handling
	localparam int unsigned ACT_MIN     = 0;
	localparam int unsigned ACT_MAX     = 255;
	localparam bit          ANTI_WINDUP = 1'b1;

	localparam logic signed [U_W-1:0]   ACT_MIN_U   = U_W'(ACT_MIN);
	localparam logic signed [U_W-1:0]   ACT_MAX_U   = U_W'(ACT_MAX);
	localparam logic [DRIVE_W-1:0]      ACT_MIN_DRV = DRIVE_W'(ACT_MIN);
	localparam logic [DRIVE_W-1:0]      ACT_MAX_DRV = DRIVE_W'(ACT_MAX);

	localparam logic signed [ACC_W-1:0] ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic signed [WND_W-1:0] WND_MAX  = {1'b0, {(WND_W-1){1'b1}}};
	localparam logic signed [WND_W-1:0] WND_MIN  = {1'b1, {(WND_W-1){1'b0}}};
	localparam logic signed [TOT_W-1:0] HALF_Q16 = TOT_W'(32768);
	localparam logic signed [TOT_W-1:0] RND_BIAS = TOT_W'(65535);

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REFERENCE     = 4'd0,
		REG_SETPOINT_TERM = 4'd1,
		REG_KP            = 4'd2,
		REG_K_INTEGRAL    = 4'd3,
		REG_K_DERIV_POLE  = 4'd4,
		REG_K_DERIV_GAIN  = 4'd5,
		REG_WINDUP_GAIN   = 4'd6,
		REG_DEAD_BAND     = 4'd7
	} cfg_reg_t;

	// Register reset values
	localparam logic [LUX_W-1:0] RST_REFERENCE     = 16'd560;
	localparam logic [CFG_W-1:0] RST_SETPOINT_TERM = 32'd3096576;
	localparam logic [CFG_W-1:0] RST_KP            = 32'd88474;
	localparam logic [CFG_W-1:0] RST_K_INTEGRAL    = 32'd25215;
	localparam logic [CFG_W-1:0] RST_K_DERIV_POLE  = 32'd0;
	localparam logic [CFG_W-1:0] RST_K_DERIV_GAIN  = 32'd0;
	localparam logic [CFG_W-1:0] RST_WINDUP_GAIN   = 32'd48497;
	localparam logic [DB_W-1:0]  RST_DEAD_BAND     = 16'd32;

	typedef struct packed {
		logic [LUX_W-1:0] reference;
		logic [CFG_W-1:0] setpoint_term;
		logic [CFG_W-1:0] kp;
		logic [CFG_W-1:0] k_integral;
		logic [CFG_W-1:0] k_deriv_pole;
		logic [CFG_W-1:0] k_deriv_gain;
		logic [CFG_W-1:0] windup_gain;
		logic [DB_W-1:0]  dead_band;
	} pidawdz_cfg_t;

	// Pipeline strobes from the flow control
	typedef struct packed {
		logic load_s1;
		logic adv_s1;
		logic adv_s2;
	} pidawdz_ctl_t;

	// Feed-forward terms handed from the front end to the accumulator stage
	typedef struct packed {
		logic [P_W-1:0]   p;
		logic [INC_W-1:0] i_inc;
		logic [INC_W-1:0] d_inc;
	} pidawdz_terms_t;

	// Clip a wide sum to the signed accumulator range
	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
		if (v > SUM_W'(ACC_MAX)) begin
			return ACC_MAX;
		end else if (v < SUM_W'(ACC_MIN)) begin
			return ACC_MIN;
		end else begin
			return ACC_W'(v);
		end
	endfunction

	// Clip an overshoot to the signed windup range
	function automatic logic signed [WND_W-1:0] sat_wnd(input logic signed [U_W:0] v);
		if (v > (U_W+1)'(WND_MAX)) begin
			return WND_MAX;
		end else if (v < (U_W+1)'(WND_MIN)) begin
			return WND_MIN;
		end else begin
			return WND_W'(v);
		end
	endfunction

endpackage

### hw/rtl/pidawdz_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller sample channel
// Valid/ready channel carrying one measured light sample per beat.
// ----------------------------------------------------------------------------
interface pidawdz_in_if;
	import pidawdz_pkg::*;

	logic             valid;
	logic             ready;
	logic [LUX_W-1:0] measured_lux;

	modport source (output valid, output measured_lux, input ready);
	modport sink   (input valid, input measured_lux, output ready);

endinterface

### hw/rtl/pidawdz_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller command channel
// Valid/ready channel carrying one actuator command per beat.
// ----------------------------------------------------------------------------
interface pidawdz_out_if;
	import pidawdz_pkg::*;

	logic               valid;
	logic               ready;
	logic [DRIVE_W-1:0] drive;
	logic               saturated;

	modport source (output valid, output drive, output saturated, input ready);
	modport sink   (input valid, input drive, input saturated, output ready);

endinterface

### hw/rtl/pidawdz_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller configuration registers
// Write-only register file; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module pidawdz_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [pidawdz_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pidawdz_pkg::CFG_W-1:0]        cfg_wdata,
	output pidawdz_pkg::pidawdz_cfg_t            cfg
);
	import pidawdz_pkg::*;

	pidawdz_cfg_t cfg_q;

	// Decode the index and update the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reference     <= RST_REFERENCE;
			cfg_q.setpoint_term <= RST_SETPOINT_TERM;
			cfg_q.kp            <= RST_KP;
			cfg_q.k_integral    <= RST_K_INTEGRAL;
			cfg_q.k_deriv_pole  <= RST_K_DERIV_POLE;
			cfg_q.k_deriv_gain  <= RST_K_DERIV_GAIN;
			cfg_q.windup_gain   <= RST_WINDUP_GAIN;
			cfg_q.dead_band     <= RST_DEAD_BAND;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_REFERENCE:     cfg_q.reference     <= cfg_wdata[LUX_W-1:0];
				REG_SETPOINT_TERM: cfg_q.setpoint_term <= cfg_wdata;
				REG_KP:            cfg_q.kp            <= cfg_wdata;
				REG_K_INTEGRAL:    cfg_q.k_integral    <= cfg_wdata;
				REG_K_DERIV_POLE:  cfg_q.k_deriv_pole  <= cfg_wdata;
				REG_K_DERIV_GAIN:  cfg_q.k_deriv_gain  <= cfg_wdata;
				REG_WINDUP_GAIN:   cfg_q.windup_gain   <= cfg_wdata;
				REG_DEAD_BAND:     cfg_q.dead_band     <= cfg_wdata[DB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hw/rtl/pidawdz_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller front end
// Input register, error with dead band, and the P, I-increment and
// D-increment products that depend only on samples and configuration.
// ----------------------------------------------------------------------------
`include "pid_with_antiwindup_deadzone_macros.svh"

module pidawdz_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pidawdz_pkg::pidawdz_cfg_t         cfg,
	input  pidawdz_pkg::pidawdz_ctl_t         ctl,
	input  logic [pidawdz_pkg::LUX_W-1:0]     measured_lux,
	output pidawdz_pkg::pidawdz_terms_t       terms
);
	import pidawdz_pkg::*;

	logic [LUX_W-1:0]            lux_s1;
	pidawdz_terms_t              terms_s2;
	logic [LUX_W-1:0]            last_meas_q;
	logic signed [ERR_W-1:0]     last_err_q;

	logic signed [ERR_W-1:0]     err_raw;
	logic signed [ERR_W-1:0]     err_dz;
	logic signed [ERR_W-1:0]     db_pos;
	logic signed [ERR_W-1:0]     db_neg;
	logic                        in_band;
	logic signed [ERR_W:0]       err_pair;
	logic signed [ERR_W-1:0]     lux_diff;
	logic signed [KP_PROD_W-1:0] kp_prod;
	logic signed [KI_PROD_W-1:0] ki_prod;
	logic signed [KD_PROD_W-1:0] kd_prod;
	pidawdz_terms_t              terms_n;

	// Capture the accepted sample
	always_ff @(posedge clk) begin
		if (ctl.load_s1) begin
			lux_s1 <= measured_lux;
		end
	end

	// Error against the reference, zeroed inside the dead band unless its width is negative
	always_comb begin
		err_raw = $signed({1'b0, cfg.reference}) - $signed({1'b0, lux_s1});
		db_pos  = ERR_W'($signed(cfg.dead_band));
		db_neg  = -db_pos;
		in_band = !cfg.dead_band[DB_W-1] && (err_raw >= db_neg) && (err_raw <= db_pos);
		err_dz  = in_band ? '0 : err_raw;
	end

	// Products that need no feedback from the accumulators
	always_comb begin
		err_pair = err_dz + last_err_q;
		lux_diff = $signed({1'b0, lux_s1}) - $signed({1'b0, last_meas_q});
		kp_prod  = $signed(cfg.kp) * $signed({1'b0, lux_s1});
		ki_prod  = $signed(cfg.k_integral) * err_pair;
		kd_prod  = $signed(cfg.k_deriv_gain) * lux_diff;

		terms_n.p     = P_W'($signed(cfg.setpoint_term) - (kp_prod >>> LUX_FRAC));
		terms_n.i_inc = INC_W'(ki_prod >>> LUX_FRAC);
		terms_n.d_inc = INC_W'(kd_prod >>> LUX_FRAC);
	end

	// Hand the terms on to the accumulator stage
	always_ff @(posedge clk) begin
		if (ctl.adv_s1) begin
			terms_s2 <= terms_n;
		end
	end

	// Keep the previous sample and error for the next beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_meas_q <= '0;
			last_err_q  <= '0;
		end else if (ctl.adv_s1) begin
			last_meas_q <= lux_s1;
			last_err_q  <= err_dz;
		end
	end

	assign terms = terms_s2;

	`PIDAWDZ_ASSERT_NEXT(a_err_hold, !ctl.adv_s1, $stable(last_err_q) && $stable(last_meas_q), "front history changed without a beat")

endmodule

### hw/rtl/pidawdz_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller accumulator stage
// I and D accumulators with back-calculation windup, rounding, clipping
// and the result register.
// ----------------------------------------------------------------------------
`include "pid_with_antiwindup_deadzone_macros.svh"

module pidawdz_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pidawdz_pkg::pidawdz_cfg_t         cfg,
	input  pidawdz_pkg::pidawdz_ctl_t         ctl,
	input  pidawdz_pkg::pidawdz_terms_t       terms,
	output logic [pidawdz_pkg::DRIVE_W-1:0]   drive,
	output logic                              saturated
);
	import pidawdz_pkg::*;

	logic signed [ACC_W-1:0]       integral_q;
	logic signed [ACC_W-1:0]       deriv_q;
	logic signed [WND_W-1:0]       windup_q;
	logic [DRIVE_W-1:0]            drive_q;
	logic                          saturated_q;

	logic signed [2*CFG_W-1:0]     wnd_prod;
	logic signed [2*CFG_W-1:0]     pole_hi;
	logic signed [CFG_W+FRAC_W:0]  pole_lo;
	logic signed [SUM_W-1:0]       i_sum;
	logic signed [SUM_W-1:0]       d_sum;
	logic signed [ACC_W-1:0]       i_new;
	logic signed [ACC_W-1:0]       d_new;
	logic signed [TOT_W-1:0]       total;
	logic signed [TOT_W-1:0]       rounded;
	logic signed [U_W-1:0]         u_val;
	logic signed [U_W-1:0]         lim;
	logic signed [U_W:0]           overshoot;
	logic                          over;
	logic                          under;
	logic                          clip;
	logic signed [WND_W-1:0]       wnd_next;
	logic [DRIVE_W-1:0]            drive_n;

	// Integral with windup correction, filtered derivative split in two halves
	always_comb begin
		wnd_prod = $signed(cfg.windup_gain) * windup_q;
		i_sum    = integral_q + $signed(terms.i_inc) + wnd_prod;
		i_new    = sat_acc(i_sum);

		pole_hi  = $signed(cfg.k_deriv_pole) * $signed(deriv_q[ACC_W-1:FRAC_W]);
		pole_lo  = $signed(cfg.k_deriv_pole) * $signed({1'b0, deriv_q[FRAC_W-1:0]});
		d_sum    = pole_hi + (pole_lo >>> FRAC_W) - $signed(terms.d_inc);
		d_new    = sat_acc(d_sum);
	end

	// Add one half, truncate toward zero, clip to the actuator range
	always_comb begin
		total     = $signed(terms.p) + i_new + d_new + HALF_Q16;
		rounded   = total[TOT_W-1] ? (total + RND_BIAS) : total;
		u_val     = U_W'(rounded >>> FRAC_W);
		over      = u_val > ACT_MAX_U;
		under     = u_val < ACT_MIN_U;
		clip      = over || under;
		lim       = over ? ACT_MAX_U : ACT_MIN_U;
		overshoot = lim - u_val;
		drive_n   = clip ? lim[DRIVE_W-1:0] : u_val[DRIVE_W-1:0];

		if (!clip) begin
			wnd_next = '0;
		end else if (ANTI_WINDUP) begin
			wnd_next = sat_wnd(overshoot);
		end else begin
			wnd_next = windup_q;
		end
	end

	// Advance the controller state once per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
			deriv_q    <= '0;
			windup_q   <= '0;
		end else if (ctl.adv_s2) begin
			integral_q <= i_new;
			deriv_q    <= d_new;
			windup_q   <= wnd_next;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (ctl.adv_s2) begin
			drive_q     <= drive_n;
			saturated_q <= clip;
		end
	end

	assign drive     = drive_q;
	assign saturated = saturated_q;

	`PIDAWDZ_ASSERT_NEXT(a_windup_clear, ctl.adv_s2 && !clip, windup_q == '0, "windup not cleared after unclipped beat")
	`PIDAWDZ_ASSERT_NEXT(a_acc_hold, !ctl.adv_s2, $stable(integral_q) && $stable(deriv_q), "accumulators moved without a beat")

endmodule

### hw/rtl/pid_with_antiwindup_deadzone.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID light controller with dead band and back-calculation anti-windup
// Takes measured light samples and returns clipped actuator commands.
// ----------------------------------------------------------------------------
// Accepts one sample per clock unless the command port stalls, and returns
// one command per sample, in order. Each command passes three registers: an
// input register, a register holding the P term and the I and D increments,
// then the result register. The I and D accumulators and the windup
// overshoot update once per sample, and that loop through the accumulator
// stage sets the rate of one sample per cycle. A stalled command port fills
// the three stages before the sample port drops ready. There is no clearing
// pass after reset. Write configuration only while no sample is in flight;
// writes to indexes beyond the register list are ignored.
`include "pid_with_antiwindup_deadzone_macros.svh"

module pid_with_antiwindup_deadzone (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [pidawdz_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pidawdz_pkg::CFG_W-1:0]      cfg_wdata,
	pidawdz_in_if.sink                         sample,
	pidawdz_out_if.source                      command
);
	import pidawdz_pkg::*;

	pidawdz_cfg_t   cfg;
	pidawdz_ctl_t   ctl;
	pidawdz_terms_t terms;

	logic valid_s1;
	logic valid_s2;
	logic cmd_valid_q;
	logic res_free;
	logic s2_free;
	logic s1_free;

	// Move a beat forward wherever the next stage is empty or draining
	always_comb begin
		res_free    = !cmd_valid_q || command.ready;
		s2_free     = !valid_s2 || res_free;
		s1_free     = !valid_s1 || s2_free;
		ctl.load_s1 = sample.valid && s1_free;
		ctl.adv_s1  = valid_s1 && s2_free;
		ctl.adv_s2  = valid_s2 && res_free;
	end

	// Stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			cmd_valid_q <= 1'b0;
		end else begin
			valid_s1    <= ctl.load_s1 || (valid_s1 && !ctl.adv_s1);
			valid_s2    <= ctl.adv_s1 || (valid_s2 && !ctl.adv_s2);
			cmd_valid_q <= ctl.adv_s2 || (cmd_valid_q && !command.ready);
		end
	end

	pidawdz_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pidawdz_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.ctl          (ctl),
		.measured_lux (sample.measured_lux),
		.terms        (terms)
	);

	pidawdz_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.ctl       (ctl),
		.terms     (terms),
		.drive     (command.drive),
		.saturated (command.saturated)
	);

	assign sample.ready  = s1_free;
	assign command.valid = cmd_valid_q;

	`PIDAWDZ_ASSERT_SAME(a_ready_when_drained, !cmd_valid_q, sample.ready, "sample port stalled with empty result stage")
	`PIDAWDZ_ASSERT_SAME(a_full_stall, valid_s1 && valid_s2 && cmd_valid_q && !command.ready, !sample.ready, "beat taken into a full pipeline")
	`PIDAWDZ_ASSERT_NEXT(a_result_loaded, ctl.adv_s2, command.valid, "command lost between stages")
	`PIDAWDZ_ASSERT_SAME(a_clip_at_limit, command.valid && command.saturated, command.drive == ACT_MIN_DRV || command.drive == ACT_MAX_DRV, "clipped command not at a limit")

endmodule

### test/pid_command_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller command checker
// Mirrors the register writes and predicts one command for every accepted
// sample beat. Each command beat that leaves the block is compared, field by
// field, with the oldest predicted command.
// ----------------------------------------------------------------------------
module pid_command_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [pidawdz_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pidawdz_pkg::CFG_W-1:0]     cfg_wdata,
	pidawdz_in_if                             sample,
	pidawdz_out_if                            command,
	output int                                fail_count,
	output int                                pending,
	output int                                samples_seen,
	output int                                commands_seen,
	output int                                clipped_seen
);
	import pidawdz_pkg::*;

	localparam longint ACC_HI     = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint ACC_LO     = -ACC_HI - 1;
	localparam longint WND_HI     = 64'sh0000_0000_7FFF_FFFF;
	localparam longint WND_LO     = -WND_HI - 1;
	localparam longint ROUND_HALF = 32768;
	localparam int     SHOW_MAX   = 10;

	typedef struct packed {
		logic [DRIVE_W-1:0] drive;
		logic               saturated;
	} command_t;

	// Mirrored registers
	logic [LUX_W-1:0]        target_lux;
	logic signed [CFG_W-1:0] sp_term;
	logic signed [CFG_W-1:0] kp_gain;
	logic signed [CFG_W-1:0] ki_gain;
	logic signed [CFG_W-1:0] kd_pole;
	logic signed [CFG_W-1:0] kd_gain;
	logic signed [CFG_W-1:0] aw_gain;
	logic signed [DB_W-1:0]  band;

	// Controller state carried from one sample to the next
	logic [LUX_W-1:0]   prev_lux;
	logic signed [16:0] prev_err;
	logic signed [47:0] integ_acc;
	logic signed [47:0] deriv_acc;
	logic signed [31:0] windup_err;

	command_t expected_cmds[$];

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Work out the command for one sample and advance the controller state
	function automatic command_t predict_command(input logic [LUX_W-1:0] lux);
		longint   lx, err, db, p, i_new, d_new, hi, lo, tot, u, lim;
		command_t res;
		lx  = longint'(lux);
		err = longint'(target_lux) - lx;
		db  = longint'(band);
		res.saturated = 1'b0;

		// zero the error inside the dead band; a negative width disables it
		if (db >= 0 && err >= -db && err <= db) begin
			err = 0;
		end

		p = longint'(sp_term) - ((longint'(kp_gain) * lx) >>> 4);

		i_new = longint'(integ_acc)
			+ ((longint'(ki_gain) * (err + longint'(prev_err))) >>> 4)
			+ longint'(aw_gain) * longint'(windup_err);
		i_new = clip(i_new, ACC_LO, ACC_HI);

		// pole times the 48 bit term, split so that no product overflows
		hi    = longint'(deriv_acc) >>> 16;
		lo    = longint'(deriv_acc) - hi * 65536;
		d_new = longint'(kd_pole) * hi + ((longint'(kd_pole) * lo) >>> 16)
			- ((longint'(kd_gain) * (lx - longint'(prev_lux))) >>> 4);
		d_new = clip(d_new, ACC_LO, ACC_HI);

		// add one half, truncate toward zero
		tot = p + i_new + d_new + ROUND_HALF;
		u   = (tot >= 0) ? (tot >>> 16) : -((-tot) >>> 16);

		// clip and keep the overshoot for the next windup correction
		if (u > longint'(ACT_MAX) || u < longint'(ACT_MIN)) begin
			lim = (u > longint'(ACT_MAX)) ? longint'(ACT_MAX) : longint'(ACT_MIN);
			if (ANTI_WINDUP) begin
				windup_err = 32'(clip(lim - u, WND_LO, WND_HI));
			end
			u = lim;
			res.saturated = 1'b1;
		end else begin
			windup_err = '0;
		end

		prev_lux  = lux;
		prev_err  = 17'(err);
		integ_acc = 48'(i_new);
		deriv_acc = 48'(d_new);
		res.drive = u[DRIVE_W-1:0];
		return res;
	endfunction

	// Watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin : watch
		command_t want;
		if (!arst_n) begin
			target_lux    = RST_REFERENCE;
			sp_term       = RST_SETPOINT_TERM;
			kp_gain       = RST_KP;
			ki_gain       = RST_K_INTEGRAL;
			kd_pole       = RST_K_DERIV_POLE;
			kd_gain       = RST_K_DERIV_GAIN;
			aw_gain       = RST_WINDUP_GAIN;
			band          = RST_DEAD_BAND;
			prev_lux      = '0;
			prev_err      = '0;
			integ_acc     = '0;
			deriv_acc     = '0;
			windup_err    = '0;
			expected_cmds.delete();
			fail_count    <= 0;
			pending       <= 0;
			samples_seen  <= 0;
			commands_seen <= 0;
			clipped_seen  <= 0;
		end else begin
			// compare a command beat with the oldest prediction
			if (command.valid && command.ready) begin
				commands_seen <= commands_seen + 1;
				if (command.saturated) begin
					clipped_seen <= clipped_seen + 1;
				end
				if (expected_cmds.size() == 0) begin
					if (fail_count < SHOW_MAX) begin
						$display("[%0t] command %0d with none expected: drive %0d saturated %0b",
							$realtime, commands_seen, command.drive, command.saturated);
					end
					fail_count <= fail_count + 1;
				end else begin
					want = expected_cmds.pop_front();
					if (command.drive !== want.drive || command.saturated !== want.saturated) begin
						if (fail_count < SHOW_MAX) begin
							$display("[%0t] command %0d: drive exp %0d got %0d, saturated exp %0b got %0b",
								$realtime, commands_seen, want.drive, command.drive,
								want.saturated, command.saturated);
						end
						fail_count <= fail_count + 1;
					end
				end
			end

			// predict a command for each sample beat
			if (sample.valid && sample.ready) begin
				expected_cmds.push_back(predict_command(sample.measured_lux));
				samples_seen <= samples_seen + 1;
			end

			// mirror register writes; unknown indexes are dropped
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
					REG_REFERENCE:     target_lux = cfg_wdata[LUX_W-1:0];
					REG_SETPOINT_TERM: sp_term    = cfg_wdata;
					REG_KP:            kp_gain    = cfg_wdata;
					REG_K_INTEGRAL:    ki_gain    = cfg_wdata;
					REG_K_DERIV_POLE:  kd_pole    = cfg_wdata;
					REG_K_DERIV_GAIN:  kd_gain    = cfg_wdata;
					REG_WINDUP_GAIN:   aw_gain    = cfg_wdata;
					REG_DEAD_BAND:     band       = cfg_wdata[DB_W-1:0];
					default: ;
				endcase
			end

			pending <= expected_cmds.size();
		end
	end

endmodule

### test/tb_pid_with_antiwindup_deadzone.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller testbench
// Drives light samples through the controller under several gain settings,
// from reset values to both extremes, with random gaps on the sample side and
// random stalls on the command side. A checker beside the block predicts and
// compares every command; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_pid_with_antiwindup_deadzone;
	import pidawdz_pkg::*;

	localparam int                   LIMIT_CYCLES  = 300000;
	localparam int                   IDLE_PCT      = 31;
	localparam int                   LONG_HOLD     = 150;
	localparam int                   PIPE_DEPTH    = 3;
	localparam logic [CFG_IDX_W-1:0] UNMAPPED_BASE = 4'd8;
	localparam logic [LUX_W-1:0]     EDGE_LUX [18] = '{
		16'd0, 16'd65535, 16'd560, 16'd528, 16'd527, 16'd592, 16'd593,
		16'd65535, 16'd65535, 16'd0, 16'd0, 16'd0, 16'd560, 16'd1,
		16'd32768, 16'd65534, 16'd559, 16'd561
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	pidawdz_in_if  sample_ch ();
	pidawdz_out_if command_ch ();

	int fail_count;
	int pending;
	int samples_seen;
	int commands_seen;
	int clipped_seen;
	int cycle_count = 0;
	int settings_used = 1;

	logic         calm = 1'b0;
	logic         hold_off_req = 1'b0;
	logic [15:0]  last_lux = '0;
	pidawdz_cfg_t gains;

	pid_with_antiwindup_deadzone u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.sample    (sample_ch),
		.command   (command_ch)
	);

	pid_command_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.sample        (sample_ch),
		.command       (command_ch),
		.fail_count    (fail_count),
		.pending       (pending),
		.samples_seen  (samples_seen),
		.commands_seen (commands_seen),
		.clipped_seen  (clipped_seen)
	);

	always #4 clk = ~clk;

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Timed out after %0d cycles with %0d commands outstanding",
				cycle_count, pending);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Command side: random stalls, one long hold-off, a calm stretch
	initial begin : command_side
		int hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		command_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req && !held) begin
				held = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				command_ch.ready <= 1'b0;
				hold_left--;
			end else if (calm) begin
				command_ch.ready <= 1'b1;
			end else begin
				command_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// Offer one sample beat, after a random gap, and hold it until taken
	task automatic push_sample(input logic [LUX_W-1:0] lux);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid        <= 1'b1;
		sample_ch.measured_lux <= lux;
		do @(posedge clk); while (!sample_ch.ready);
		last_lux = lux;
	endtask

	// Drop valid and wait until every predicted command has come out
	task automatic drain();
		sample_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (PIPE_DEPTH + 1) @(posedge clk);
	endtask

	// Samples near the reference, drifting from the last one, or anywhere
	task automatic run_samples(input int count);
		int k, pick, v;
		for (k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				v = int'(gains.reference) + int'($urandom_range(0, 160)) - 80;
			end else if (pick < 75) begin
				v = int'(last_lux) + int'($urandom_range(0, 128)) - 64;
			end else begin
				v = int'($urandom_range(0, 65535));
			end
			if (v < 0) begin
				v = 0;
			end else if (v > 65535) begin
				v = 65535;
			end
			push_sample(16'(v));
		end
	endtask

	task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// Write every register from gains, then poke an index past the list
	task automatic load_gains();
		cfg_put(REG_REFERENCE, {16'($urandom), gains.reference});
		cfg_put(REG_SETPOINT_TERM, gains.setpoint_term);
		cfg_put(REG_KP, gains.kp);
		cfg_put(REG_K_INTEGRAL, gains.k_integral);
		cfg_put(REG_K_DERIV_POLE, gains.k_deriv_pole);
		cfg_put(REG_K_DERIV_GAIN, gains.k_deriv_gain);
		cfg_put(REG_WINDUP_GAIN, gains.windup_gain);
		cfg_put(REG_DEAD_BAND, {16'($urandom), gains.dead_band});
		cfg_put(UNMAPPED_BASE + CFG_IDX_W'($urandom_range(0, 7)), $urandom);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	function automatic logic [CFG_W-1:0] rand_gain();
		case ($urandom_range(0, 3))
			0:       return 32'($urandom_range(0, 32'h0004_0000));
			1:       return 32'(-int'($urandom_range(0, 32'h0004_0000)));
			2:       return 32'($urandom_range(32'h0000_8000, 32'h0002_0000));
			default: return $urandom;
		endcase
	endfunction

	task automatic pick_random_gains();
		gains.reference     = 16'($urandom_range(0, 65535));
		gains.setpoint_term = rand_gain();
		gains.kp            = rand_gain();
		gains.k_integral    = rand_gain();
		gains.k_deriv_pole  = rand_gain();
		gains.k_deriv_gain  = rand_gain();
		gains.windup_gain   = rand_gain();
		case ($urandom_range(0, 2))
			0:       gains.dead_band = 16'($urandom_range(0, 96));
			1:       gains.dead_band = 16'(-int'($urandom_range(1, 32768)));
			default: gains.dead_band = 16'($urandom);
		endcase
	endtask

	task automatic uniform_gains(input logic [CFG_W-1:0] g, input logic [LUX_W-1:0] refv,
		input logic [DB_W-1:0] db);
		gains.reference     = refv;
		gains.setpoint_term = g;
		gains.kp            = g;
		gains.k_integral    = g;
		gains.k_deriv_pole  = g;
		gains.k_deriv_gain  = g;
		gains.windup_gain   = g;
		gains.dead_band     = db;
	endtask

	initial begin : stimulus
		int k;
		arst_n                 = 1'b0;
		cfg_wr_en              = 1'b0;
		cfg_index              = '0;
		cfg_wdata              = '0;
		sample_ch.valid        = 1'b0;
		sample_ch.measured_lux = '0;
		gains.reference        = RST_REFERENCE;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset gains: field extremes, dead band edges, windup both ways
		for (k = 0; k < $size(EDGE_LUX); k++) begin
			push_sample(EDGE_LUX[k]);
		end
		run_samples(150);
		drain();

		// moderate gains with the D path live; hold the command side off
		gains.reference     = 16'd800;
		gains.setpoint_term = 32'h0030_0000;
		gains.kp            = 32'h0001_0000;
		gains.k_integral    = 32'h0000_4000;
		gains.k_deriv_pole  = 32'h0000_C000;
		gains.k_deriv_gain  = 32'h0002_0000;
		gains.windup_gain   = 32'h0000_8000;
		gains.dead_band     = 16'd16;
		load_gains();
		hold_off_req <= 1'b1;
		run_samples(110);
		drain();
		run_samples(110);
		drain();

		// largest positive values: terms and overshoot saturate
		uniform_gains(32'h7FFF_FFFF, 16'hFFFF, 16'h7FFF);
		load_gains();
		run_samples(150);
		drain();

		// most negative values, dead band disabled
		uniform_gains(32'h8000_0000, 16'h0000, 16'h8000);
		load_gains();
		run_samples(150);
		drain();

		// zero gains with the band just disabled, then a band of width zero
		uniform_gains(32'h0000_0000, 16'($urandom), 16'hFFFF);
		gains.setpoint_term = $urandom;
		load_gains();
		run_samples(60);
		drain();
		pick_random_gains();
		gains.dead_band = 16'd0;
		load_gains();
		run_samples(40);
		drain();

		// random settings, one of them without any idling
		for (k = 0; k < 5; k++) begin
			pick_random_gains();
			load_gains();
			calm <= (k == 2);
			run_samples(130);
			drain();
		end

		$display("Covered %0d samples and %0d commands (%0d clipped) over %0d gain settings,",
			samples_seen, commands_seen, clipped_seen, settings_used);
		$display("incl. both gain extremes, dead band on and off and a long command stall.");
		if (fail_count == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

### pid_with_antiwindup_deadzone.f
+incdir+hw/rtl
hw/rtl/pidawdz_pkg.sv
hw/rtl/pidawdz_in_if.sv
hw/rtl/pidawdz_out_if.sv
hw/rtl/pidawdz_cfg_regs.sv
hw/rtl/pidawdz_front.sv
hw/rtl/pidawdz_core.sv
hw/rtl/pid_with_antiwindup_deadzone.sv
test/pid_command_checker.sv
test/tb_pid_with_antiwindup_deadzone.sv
